[rtl/core/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Default field widths and hue sextant codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned ColorBitsDefault = 8;
  localparam int unsigned HueBitsDefault   = 16;

  // Hue sextants, named by the colors at their two ends
  typedef enum logic [2:0] {
    SextRedYellow    = 3'd0,
    SextYellowGreen  = 3'd1,
    SextGreenCyan    = 3'd2,
    SextCyanBlue     = 3'd3,
    SextBlueMagenta  = 3'd4,
    SextMagentaRed   = 3'd5
  } sext_e;

endpackage

`default_nettype wire

[rtl/core/hsv_to_rgb_converter_top.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Four-stage pipeline converting one HSV pixel to one RGB pixel per clock when not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: hue_i, saturation_i, brightness_i with in_valid_i and
//   in_stall_o. A pixel transfers on a clock edge with in_valid_i high and
//   in_stall_o low. Hue is a fraction of a full turn (2^HUE_BITS = 360 deg),
//   saturation and brightness are all-ones for 1.0.
//   Output channel: red_o, green_o, blue_o with out_valid_o and out_stall_i,
//   same transfer rule. Channels are rounded half up to COLOR_BITS.
//   A pixel passes the s1, s2, s3 and output registers to out_valid_o.
//   Throughput: one pixel per clock while out_stall_i is low; each stage
//   holds one pixel and the per-stage handshake lets bubbles close up.
//   Stage work: hue sextant and v*s product; intermediate product and
//   offset; rounding add; divide by full scale and channel select.
//   Reset empties all stages; out_valid_o is low after reset.
//   While out_stall_i is high the output pixel holds, and the earlier stages
//   keep filling until they are all occupied, then in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_top #(
  parameter int unsigned COLOR_BITS = hsv2rgb_pkg::ColorBitsDefault,
  parameter int unsigned HUE_BITS   = hsv2rgb_pkg::HueBitsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [HUE_BITS-1:0]   hue_i,
  input  wire logic [COLOR_BITS-1:0] saturation_i,
  input  wire logic [COLOR_BITS-1:0] brightness_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [COLOR_BITS-1:0] red_o,
  output      logic [COLOR_BITS-1:0] green_o,
  output      logic [COLOR_BITS-1:0] blue_o
);

  localparam int unsigned VsW  = 2 * COLOR_BITS;
  localparam int unsigned XW   = 2 * COLOR_BITS + HUE_BITS;
  localparam int unsigned PosW = HUE_BITS + 3;
  localparam int unsigned TW   = HUE_BITS + 1;

  // full scale M, M*2^(HUE_BITS-1) and (M-1)/2
  localparam logic [COLOR_BITS:0] MaxC = {1'b0, {COLOR_BITS{1'b1}}};
  localparam logic [XW-1:0] RoundX =
    {{(XW-COLOR_BITS){1'b0}}, {COLOR_BITS{1'b1}}} << (HUE_BITS - 1);
  localparam logic [VsW-1:0] HalfM = {{(COLOR_BITS+1){1'b0}}, {(COLOR_BITS-1){1'b1}}};

  // floor(n / M) for n < M * 2^COLOR_BITS: one fold and one correction
  function automatic logic [COLOR_BITS-1:0] div_m(input logic [VsW-1:0] n);
    logic [COLOR_BITS-1:0] q0;
    logic [COLOR_BITS:0]   r0;
    q0 = n[VsW-1:COLOR_BITS];
    r0 = {1'b0, n[COLOR_BITS-1:0]} + {1'b0, q0};
    div_m = (r0 >= MaxC) ? q0 + COLOR_BITS'(1) : q0;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  assign s4_ready   = !out_valid_q || !out_stall_i;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (s4_ready) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sextant, intermediate weight, v*s
  // --------------------------------------------------------------------------
  logic [PosW-1:0]       pos;
  logic [HUE_BITS-1:0]   frac;
  hsv2rgb_pkg::sext_e    s1_sext_d, s1_sext_q;
  logic [TW-1:0]         s1_t_d, s1_t_q;
  logic [VsW-1:0]        s1_vs_d, s1_vs_q;
  logic [COLOR_BITS-1:0] s1_v_q;

  always_comb begin
    pos       = (PosW'(hue_i) << 2) + (PosW'(hue_i) << 1);
    frac      = pos[HUE_BITS-1:0];
    s1_sext_d = hsv2rgb_pkg::sext_e'(pos[PosW-1:HUE_BITS]);
    // falling edge of the ramp in odd sextants
    s1_t_d    = pos[HUE_BITS] ? ({1'b1, {HUE_BITS{1'b0}}} - {1'b0, frac})
                              : {1'b0, frac};
    s1_vs_d   = VsW'(brightness_i) * VsW'(saturation_i);
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_sext_q <= s1_sext_d;
      s1_t_q    <= s1_t_d;
      s1_vs_q   <= s1_vs_d;
      s1_v_q    <= brightness_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: intermediate product and offset numerator
  // --------------------------------------------------------------------------
  logic [XW-1:0]         s2_xn_d, s2_xn_q;
  logic [VsW-1:0]        s2_zn_d, s2_zn_q;
  hsv2rgb_pkg::sext_e    s2_sext_q;
  logic [COLOR_BITS-1:0] s2_v_q;

  always_comb begin
    s2_xn_d = XW'(s1_vs_q) * XW'(s1_t_q);
    // v*M - v*s, offset in units of 1/M
    s2_zn_d = {s1_v_q, {COLOR_BITS{1'b0}}} - VsW'(s1_v_q) - s1_vs_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_xn_q   <= s2_xn_d;
      s2_zn_q   <= s2_zn_d;
      s2_sext_q <= s1_sext_q;
      s2_v_q    <= s1_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: add offset and half step, drop hue scale
  // --------------------------------------------------------------------------
  logic [XW-1:0]         sum_x;
  logic [VsW-1:0]        s3_nx_q, s3_nz_d, s3_nz_q;
  hsv2rgb_pkg::sext_e    s3_sext_q;
  logic [COLOR_BITS-1:0] s3_v_q;

  always_comb begin
    sum_x   = s2_xn_q + (XW'(s2_zn_q) << HUE_BITS) + RoundX;
    s3_nz_d = s2_zn_q + HalfM;
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_nx_q   <= sum_x[XW-1:HUE_BITS];
      s3_nz_q   <= s3_nz_d;
      s3_sext_q <= s2_sext_q;
      s3_v_q    <= s2_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: divide by full scale, route to channels
  // --------------------------------------------------------------------------
  logic [COLOR_BITS-1:0] xval, zval;
  logic [COLOR_BITS-1:0] red_d, green_d, blue_d;
  logic [COLOR_BITS-1:0] red_q, green_q, blue_q;

  always_comb begin
    xval = div_m(s3_nx_q);
    zval = div_m(s3_nz_q);
    // chroma plus offset is exactly the brightness
    unique case (s3_sext_q)
      hsv2rgb_pkg::SextRedYellow: begin
        red_d = s3_v_q; green_d = xval;   blue_d = zval;
      end
      hsv2rgb_pkg::SextYellowGreen: begin
        red_d = xval;   green_d = s3_v_q; blue_d = zval;
      end
      hsv2rgb_pkg::SextGreenCyan: begin
        red_d = zval;   green_d = s3_v_q; blue_d = xval;
      end
      hsv2rgb_pkg::SextCyanBlue: begin
        red_d = zval;   green_d = xval;   blue_d = s3_v_q;
      end
      hsv2rgb_pkg::SextBlueMagenta: begin
        red_d = xval;   green_d = zval;   blue_d = s3_v_q;
      end
      default: begin
        red_d = s3_v_q; green_d = zval;   blue_d = xval;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready && s3_valid_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

`default_nettype wire

[sim/tb_hsv_to_rgb_converter_top.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// A table of directed pixels, then random pixels, goes through the valid/stall
// input channel. Each accepted pixel's expected value (typed in for known rows,
// else from an in-bench integer model) is queued; each pixel leaving the
// output channel is checked against the oldest queued one. Both sides idle at
// random; one long output hold-off fills the pipeline so it stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hsv_to_rgb_converter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = hsv2rgb_pkg::ColorBitsDefault;
  localparam int unsigned HB = hsv2rgb_pkg::HueBitsDefault;
  localparam longint unsigned FULL_SCALE = (64'd1 << CB) - 64'd1;
  localparam longint unsigned HUE_SPAN   = 64'd1 << HB;

  localparam int unsigned NUM_RANDOM   = 1100;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HB-1:0] hue;
    logic [CB-1:0] sat;
    logic [CB-1:0] bri;
    bit            known;  // expected pixel typed in below
    rgb_t          pix;
  } dir_row_t;

  localparam rgb_t NONE = '{8'd0, 8'd0, 8'd0};

  localparam int unsigned NDIR = 24;
  localparam dir_row_t DIR_TAB [NDIR] = '{
    '{16'h0000, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{16'h0000, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{16'hffff, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{16'h8000, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{16'h1234, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{16'habcd, 8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},
    '{16'hffff, 8'd255, 8'd255, 1'b0, NONE},
    // one pixel in the middle of each sextant
    '{16'h1555, 8'd255, 8'd255, 1'b0, NONE},
    '{16'h4000, 8'd200, 8'd180, 1'b0, NONE},
    '{16'h6aaa, 8'd128, 8'd255, 1'b0, NONE},
    '{16'h9555, 8'd255, 8'd100, 1'b0, NONE},
    '{16'hc000, 8'd77,  8'd201, 1'b0, NONE},
    '{16'heaaa, 8'd255, 8'd255, 1'b0, NONE},
    // either side of the sextant boundaries at 1/6, 1/3, 2/3 and 5/6 of a turn
    '{16'd10922, 8'd255, 8'd255, 1'b0, NONE},
    '{16'd10923, 8'd255, 8'd255, 1'b0, NONE},
    '{16'd21845, 8'd255, 8'd255, 1'b0, NONE},
    '{16'd21846, 8'd255, 8'd255, 1'b0, NONE},
    '{16'd43690, 8'd255, 8'd255, 1'b0, NONE},
    '{16'd43691, 8'd255, 8'd255, 1'b0, NONE},
    '{16'd54613, 8'd255, 8'd255, 1'b0, NONE},
    '{16'd54614, 8'd255, 8'd255, 1'b0, NONE},
    '{16'h5555, 8'd255, 8'd1,   1'b0, NONE},
    '{16'haaaa, 8'd1,   8'd255, 1'b0, NONE},
    '{16'hffff, 8'haa,  8'h55,  1'b0, NONE}
  };

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [HB-1:0] hue_i;
  logic [CB-1:0] saturation_i;
  logic [CB-1:0] brightness_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [CB-1:0] red_o;
  logic [CB-1:0] green_o;
  logic [CB-1:0] blue_o;

  rgb_t        rgb_expect_q[$];
  rgb_t        rgb_head;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;
  bit          quiet        = 1'b0;
  bit          hold_req     = 1'b0;

  hsv_to_rgb_converter_top #(
    .COLOR_BITS(CB),
    .HUE_BITS  (HB)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .brightness_i(brightness_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Numerator is in units of 1/(FULL_SCALE*HUE_SPAN) of an output step.
  function automatic logic [CB-1:0] to_level(longint unsigned num);
    longint unsigned den;
    longint unsigned q;
    den = FULL_SCALE * HUE_SPAN;
    q   = (num + den / 2) / den;
    return (q > FULL_SCALE) ? CB'(FULL_SCALE) : CB'(q);
  endfunction

  function automatic rgb_t hsv_predict(logic [HB-1:0] hue, logic [CB-1:0] sat,
                                       logic [CB-1:0] bri);
    longint unsigned    pos, frac, weight, vs;
    longint unsigned    chroma_n, inter_n, offset_n;
    longint unsigned    rn, gn, bn;
    hsv2rgb_pkg::sext_e sext;
    rgb_t               pix;
    pos  = 64'(hue) * 64'd6;
    sext = hsv2rgb_pkg::sext_e'(3'(pos >> HB));
    frac = pos & (HUE_SPAN - 1);
    // falling edge of the intermediate in odd sextants
    weight   = (((pos >> HB) & 64'd1) != 0) ? HUE_SPAN - frac : frac;
    vs       = 64'(bri) * 64'(sat);
    chroma_n = vs * HUE_SPAN;
    inter_n  = vs * weight;
    offset_n = 64'(bri) * FULL_SCALE * HUE_SPAN - chroma_n;
    case (sext)
      hsv2rgb_pkg::SextRedYellow: begin
        rn = chroma_n; gn = inter_n;  bn = 0;
      end
      hsv2rgb_pkg::SextYellowGreen: begin
        rn = inter_n;  gn = chroma_n; bn = 0;
      end
      hsv2rgb_pkg::SextGreenCyan: begin
        rn = 0;        gn = chroma_n; bn = inter_n;
      end
      hsv2rgb_pkg::SextCyanBlue: begin
        rn = 0;        gn = inter_n;  bn = chroma_n;
      end
      hsv2rgb_pkg::SextBlueMagenta: begin
        rn = inter_n;  gn = 0;        bn = chroma_n;
      end
      default: begin
        rn = chroma_n; gn = 0;        bn = inter_n;
      end
    endcase
    pix.red   = to_level(rn + offset_n);
    pix.green = to_level(gn + offset_n);
    pix.blue  = to_level(bn + offset_n);
    return pix;
  endfunction

  // Mostly zero, sometimes a few cycles, rarely long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [HB-1:0] random_hue();
    longint unsigned k;
    if ($urandom_range(0, 99) < 20) begin
      // close to a sextant boundary, wrapping at a full turn
      k = $urandom_range(0, 6);
      return HB'((k * HUE_SPAN) / 6 + 64'($urandom_range(0, 4)) - 64'd2);
    end
    return HB'($urandom);
  endfunction

  function automatic logic [CB-1:0] random_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return CB'(FULL_SCALE);
    if (r < 22) return CB'(1);
    return CB'($urandom_range(0, int'(FULL_SCALE)));
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_pixel(logic [HB-1:0] hue, logic [CB-1:0] sat,
                            logic [CB-1:0] bri, bit known, rgb_t fixed_pix);
    int unsigned gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    hue_i        = hue;
    saturation_i = sat;
    brightness_i = bri;
    do @(posedge clk_i); while (in_stall_o);
    rgb_expect_q.push_back(known ? fixed_pix : hsv_predict(hue, sat, bri));
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    hue_i        = '0;
    saturation_i = '0;
    brightness_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NDIR; i++) begin
      send_pixel(DIR_TAB[i].hue, DIR_TAB[i].sat, DIR_TAB[i].bri,
                 DIR_TAB[i].known, DIR_TAB[i].pix);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      quiet = (i >= 500 && i < 650);
      if (i == 300) hold_req = 1'b1;
      send_pixel(random_hue(), random_level(), random_level(), 1'b0, NONE);
    end
    in_valid_i = 1'b0;

    while (rgb_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = LONG_HOLD;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && !quiet) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rgb_expect_q.size() == 0) begin
        $error("unexpected pixel r=%0d g=%0d b=%0d", red_o, green_o, blue_o);
        mismatch_cnt++;
      end else begin
        rgb_head = rgb_expect_q.pop_front();
        if (red_o !== rgb_head.red) begin
          $error("red: expected %0d, actual %0d", rgb_head.red, red_o);
          mismatch_cnt++;
        end
        if (green_o !== rgb_head.green) begin
          $error("green: expected %0d, actual %0d", rgb_head.green, green_o);
          mismatch_cnt++;
        end
        if (blue_o !== rgb_head.blue) begin
          $error("blue: expected %0d, actual %0d", rgb_head.blue, blue_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

endmodule

`default_nettype wire
